// ===== hdl/gbag_pkg.sv =====
// Package for the glyph blit address generator.
// Holds the item payload types, the register map, and the microcode ROM.
// No dependencies.
package gbag_pkg;

    typedef struct packed {
        logic        op;
        logic [6:0]  entry_index;
        logic [7:0]  entry_code;
        logic [15:0] entry_pack;
        logic [7:0]  char_code;
        logic [8:0]  x_pos;
        logic [7:0]  y_pos;
    } t_in_item;

    typedef struct packed {
        logic [15:0] dest_offset;
        logic [15:0] source_offset;
        logic [4:0]  copy_width;
        logic        last_row;
    } t_out_item;

    // op codes of an input item
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    typedef struct packed {
        logic [7:0]  glyphs_per_row;
        logic [4:0]  cell_width;
        logic [5:0]  cell_height;
        logic [11:0] image_width;
        logic [7:0]  table_length;
        logic [15:0] dest_base;
    } t_cfg;

    localparam logic [2:0] CFG_GLYPHS_PER_ROW = 3'd0;
    localparam logic [2:0] CFG_CELL_WIDTH     = 3'd1;
    localparam logic [2:0] CFG_CELL_HEIGHT    = 3'd2;
    localparam logic [2:0] CFG_IMAGE_WIDTH    = 3'd3;
    localparam logic [2:0] CFG_TABLE_LENGTH   = 3'd4;
    localparam logic [2:0] CFG_DEST_BASE      = 3'd5;

    localparam t_cfg CFG_RESET = '{
        glyphs_per_row: 8'd0,
        cell_width:     5'd8,
        cell_height:    6'd8,
        image_width:    12'd320,
        table_length:   8'd0,
        dest_base:      16'd0
    };

    // one table slot: code plus packed descriptor
    typedef struct packed {
        logic [7:0]  code;
        logic [15:0] pack;
    } t_entry;

    // descriptor fields
    localparam int PK_ROW_LSB   = 14;
    localparam int PK_WIDTH_LSB = 9;

    // datapath actions
    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_ACCEPT,
        UOP_READ,
        UOP_DECODE,
        UOP_DIV,
        UOP_MONO,
        UOP_MUL1,
        UOP_MUL2,
        UOP_ADD,
        UOP_EMIT
    } t_uop;

    // jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_DRAW,
        C_SKIP,
        C_MISS_MORE,
        C_MATCH,
        C_PROP,
        C_DIV_MORE,
        C_NO_OUT,
        C_EMIT_LOOP
    } t_cond;

    typedef logic [3:0] t_pc;

    typedef struct packed {
        t_uop  uop;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // status flags the sequencer tests
    typedef struct packed {
        logic no_draw;
        logic skip;
        logic miss_more;
        logic match;
        logic prop;
        logic div_more;
        logic no_out;
        logic emit_loop;
    } t_stat;

    localparam t_pc S_WAIT   = 4'd0;
    localparam t_pc S_CHECK  = 4'd1;
    localparam t_pc S_READ   = 4'd2;
    localparam t_pc S_CMP    = 4'd3;
    localparam t_pc S_HIT    = 4'd4;
    localparam t_pc S_MISS   = 4'd5;
    localparam t_pc S_DECODE = 4'd6;
    localparam t_pc S_DIV    = 4'd7;
    localparam t_pc S_MONO   = 4'd8;
    localparam t_pc S_SIZE   = 4'd9;
    localparam t_pc S_BASE   = 4'd10;
    localparam t_pc S_OFFS   = 4'd11;
    localparam t_pc S_EMIT   = 4'd12;
    localparam t_pc S_DONE   = 4'd13;

    localparam int PROG_LEN = 14;

    localparam t_uword UPROG [PROG_LEN] = '{
        '{UOP_ACCEPT, C_NO_DRAW,   S_WAIT},    // S_WAIT
        '{UOP_NOP,    C_SKIP,      S_WAIT},    // S_CHECK
        '{UOP_READ,   C_NEVER,     S_WAIT},    // S_READ
        '{UOP_NOP,    C_MISS_MORE, S_READ},    // S_CMP
        '{UOP_NOP,    C_MATCH,     S_DECODE},  // S_HIT
        '{UOP_NOP,    C_ALWAYS,    S_WAIT},    // S_MISS
        '{UOP_DECODE, C_PROP,      S_SIZE},    // S_DECODE
        '{UOP_DIV,    C_DIV_MORE,  S_DIV},     // S_DIV
        '{UOP_MONO,   C_NEVER,     S_WAIT},    // S_MONO
        '{UOP_MUL1,   C_NO_OUT,    S_WAIT},    // S_SIZE
        '{UOP_MUL2,   C_NEVER,     S_WAIT},    // S_BASE
        '{UOP_ADD,    C_NEVER,     S_WAIT},    // S_OFFS
        '{UOP_EMIT,   C_EMIT_LOOP, S_EMIT},    // S_EMIT
        '{UOP_NOP,    C_ALWAYS,    S_WAIT}     // S_DONE
    };

endpackage

// ===== hdl/glyph_blit_address_generator.sv =====
// Glyph blit address generator. A draw item searches the table slot by slot,
// then emits one row copy per cell row (MAX_ROWS at most); monospace mode adds
// 8 divider steps and the x offset multiply. Output stalls hold the emit loop.
// Items are taken one at a time. Synchronous active-low reset restores the
// register defaults and the sequencer; the glyph table is not cleared.
module glyph_blit_address_generator #(
    parameter int TABLE_DEPTH  = 128,
    parameter int MAX_ROWS     = 32,
    parameter int SCREEN_WIDTH = 320
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  gbag_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output gbag_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import gbag_pkg::*;

    t_cfg  r_cfg;
    t_uop  uop;
    t_stat stat;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_GLYPHS_PER_ROW: r_cfg.glyphs_per_row <= i_cfg_data[7:0];
                CFG_CELL_WIDTH:     r_cfg.cell_width     <= i_cfg_data[4:0];
                CFG_CELL_HEIGHT:    r_cfg.cell_height    <= i_cfg_data[5:0];
                CFG_IMAGE_WIDTH:    r_cfg.image_width    <= i_cfg_data[11:0];
                CFG_TABLE_LENGTH:   r_cfg.table_length   <= i_cfg_data[7:0];
                CFG_DEST_BASE:      r_cfg.dest_base      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    gbag_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_uop   (uop)
    );

    gbag_dpath #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .MAX_ROWS     (MAX_ROWS),
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uop       (uop),
        .o_stat      (stat),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== hdl/gbag_table.sv =====
// Glyph table memory: one write port, one registered read port.
// Depends on gbag_pkg for the slot type.
module gbag_table #(
    parameter int DEPTH = 128,
    parameter int IW    = 7
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [IW-1:0]   i_waddr,
    input  gbag_pkg::t_entry i_wdata,
    input  logic            i_re,
    input  logic [IW-1:0]   i_raddr,
    output gbag_pkg::t_entry o_rdata
);
    import gbag_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/gbag_seq.sv =====
// Microcode sequencer: step counter, control ROM lookup and jump logic.
// Depends on gbag_pkg for the ROM and the control/status types.
module gbag_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gbag_pkg::t_stat i_stat,
    output gbag_pkg::t_uop  o_uop
);
    import gbag_pkg::*;

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword word;
    logic   take;

    assign word  = UPROG[r_pc];
    assign o_uop = word.uop;

    always_comb begin
        unique case (word.cond)
            C_NEVER:     take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_DRAW:   take = i_stat.no_draw;
            C_SKIP:      take = i_stat.skip;
            C_MISS_MORE: take = i_stat.miss_more;
            C_MATCH:     take = i_stat.match;
            C_PROP:      take = i_stat.prop;
            C_DIV_MORE:  take = i_stat.div_more;
            C_NO_OUT:    take = i_stat.no_out;
            C_EMIT_LOOP: take = i_stat.emit_loop;
            default:     take = 1'b1;
        endcase
        n_pc = take ? word.target : t_pc'(r_pc + 4'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== hdl/gbag_dpath.sv =====
// Datapath: item intake, table search, bitwise divider, offset arithmetic,
// and the output register. Driven by the microcode word from gbag_seq.
// Depends on gbag_pkg and gbag_table.
module gbag_dpath #(
    parameter int TABLE_DEPTH  = 128,
    parameter int MAX_ROWS     = 32,
    parameter int SCREEN_WIDTH = 320
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gbag_pkg::t_uop      i_uop,
    output gbag_pkg::t_stat     o_stat,
    input  gbag_pkg::t_cfg      i_cfg,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  gbag_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output gbag_pkg::t_out_item o_out_data
);
    import gbag_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [8:0]  DEPTH9 = 9'(TABLE_DEPTH);
    localparam logic [6:0]  MAXR7  = 7'(MAX_ROWS);
    localparam logic [15:0] SW16   = 16'(SCREEN_WIDTH);

    // item intake; nothing is taken while reset is held
    logic acc, draw_acc, we;
    assign o_in_stall = (i_uop != UOP_ACCEPT) || !i_rst_n;
    assign acc        = i_in_valid && !o_in_stall;
    assign draw_acc   = acc && (i_in_data.op == OP_DRAW);
    assign we         = acc && (i_in_data.op == OP_LOAD)
                        && ({2'b00, i_in_data.entry_index} < DEPTH9);

    // search state
    logic [IW:0]   r_idx;
    logic [IW-1:0] r_hit_idx;
    logic [7:0]    r_code;
    logic [8:0]    r_x;
    logic [7:0]    r_y;
    t_entry        rdata;
    logic [8:0]    lim;

    assign lim = ({1'b0, i_cfg.table_length} < DEPTH9) ? {1'b0, i_cfg.table_length} : DEPTH9;

    gbag_table #(
        .DEPTH (TABLE_DEPTH),
        .IW    (IW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (IW'(i_in_data.entry_index)),
        .i_wdata ('{code: i_in_data.entry_code, pack: i_in_data.entry_pack}),
        .i_re    (i_uop == UOP_READ),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (rdata)
    );

    // glyph geometry and divider
    logic [7:0]  r_row;
    logic [4:0]  r_width;
    logic [12:0] r_xoff;
    logic [7:0]  r_quo;
    logic [7:0]  r_rem;
    logic [2:0]  r_cnt;
    logic [8:0]  rem_sh;
    logic        div_ge;
    logic [8:0]  rem_diff;

    assign rem_sh   = {r_rem, r_quo[7]};
    assign div_ge   = rem_sh >= {1'b0, i_cfg.glyphs_per_row};
    assign rem_diff = rem_sh - {1'b0, i_cfg.glyphs_per_row};

    // offsets
    logic [13:0] r_sprod;
    logic [15:0] r_dprod;
    logic [15:0] r_src;
    logic [15:0] r_dest;
    logic [6:0]  r_left;
    logic [6:0]  rows;
    logic [25:0] src_prod;
    logic        can_load;
    logic        last;
    logic        emit_load;

    assign rows      = (7'(i_cfg.cell_height) < MAXR7) ? 7'(i_cfg.cell_height) : MAXR7;
    assign src_prod  = r_sprod * i_cfg.image_width;
    assign can_load  = !o_out_valid || !i_out_stall;
    assign last      = (r_left == 7'd1);
    assign emit_load = (i_uop == UOP_EMIT) && can_load;

    // status to the sequencer
    always_comb begin
        o_stat.no_draw   = !draw_acc;
        o_stat.skip      = (r_code == 8'd0) || (lim == 9'd0);
        o_stat.match     = (rdata.code == r_code);
        o_stat.miss_more = !o_stat.match && (9'(r_idx) < lim);
        o_stat.prop      = (i_cfg.glyphs_per_row == 8'd0);
        o_stat.div_more  = (r_cnt != 3'd0);
        o_stat.no_out    = (r_width == 5'd0) || (rows == 7'd0);
        o_stat.emit_loop = !(can_load && last);
    end

    always_ff @(posedge i_clk) begin
        case (i_uop)
            UOP_ACCEPT: begin
                if (draw_acc) begin
                    r_code <= i_in_data.char_code;
                    r_x    <= i_in_data.x_pos;
                    r_y    <= i_in_data.y_pos;
                    r_idx  <= '0;
                end
            end
            UOP_READ: begin
                r_hit_idx <= r_idx[IW-1:0];
                r_idx     <= r_idx + 1'b1;
            end
            UOP_DECODE: begin
                r_row   <= {6'd0, rdata.pack[PK_ROW_LSB +: 2]};
                r_width <= rdata.pack[PK_WIDTH_LSB +: 5];
                r_xoff  <= {4'd0, rdata.pack[8:0]};
                r_quo   <= 8'(r_hit_idx);
                r_rem   <= '0;
                r_cnt   <= 3'd7;
            end
            UOP_DIV: begin
                // restoring division, one quotient bit per step
                r_rem <= div_ge ? rem_diff[7:0] : rem_sh[7:0];
                r_quo <= {r_quo[6:0], div_ge};
                r_cnt <= r_cnt - 3'd1;
            end
            UOP_MONO: begin
                r_row   <= r_quo;
                r_width <= i_cfg.cell_width;
                r_xoff  <= r_rem * i_cfg.cell_width;
            end
            UOP_MUL1: begin
                r_sprod <= r_row * i_cfg.cell_height;
                r_dprod <= 16'(r_y) * SW16;
            end
            UOP_MUL2: begin
                r_src  <= src_prod[15:0];
                r_dest <= i_cfg.dest_base + r_dprod + 16'(r_x);
            end
            UOP_ADD: begin
                r_src  <= r_src + 16'(r_xoff);
                r_left <= rows;
            end
            UOP_EMIT: begin
                if (can_load) begin
                    r_dest <= r_dest + SW16;
                    r_src  <= r_src + 16'(i_cfg.image_width);
                    r_left <= r_left - 7'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (emit_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
        if (emit_load) begin
            r_out <= '{dest_offset: r_dest, source_offset: r_src,
                       copy_width: r_width, last_row: last};
        end
    end

    assign o_out_data = r_out;

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the glyph blit address generator: loads glyph tables, draws
// characters and checks every row copy against a predictor kept in step.
// Depends on gbag_pkg and glyph_blit_address_generator.
module tb_top;
    import gbag_pkg::*;

    localparam int SCREEN_W  = 320;
    localparam int TBL_DEPTH = 128;
    localparam int ROW_LIMIT = 32;
    // covers a draw item that searches the whole table and emits nothing
    localparam int DRAIN_CYC = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    // mirror of the block's registers and glyph table
    t_cfg        font_cfg;
    logic [7:0]  font_codes [TBL_DEPTH];
    logic [15:0] font_packs [TBL_DEPTH];
    t_out_item   pending_copies [$];

    int fail_cnt;
    int copy_cnt;
    int in_gap_pct;
    int out_stall_pct;
    int stall_left;

    glyph_blit_address_generator u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 7) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        fail_cnt++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("row copy %0d %s got %h want %h",
                                      copy_cnt, name, got, want));
    endtask

    // applies one accepted item to the mirror and queues the row copies it causes
    function automatic void expect_row_copies(input t_in_item it);
        int          s;
        int unsigned lim, slot, row, wid, xoff, nrows, dst, src, line;
        bit          hit;
        t_out_item   cp;
        if (it.op == OP_LOAD) begin
            font_codes[it.entry_index] = it.entry_code;
            font_packs[it.entry_index] = it.entry_pack;
            return;
        end
        if (it.char_code == 8'd0) return;
        lim = (font_cfg.table_length < TBL_DEPTH) ? font_cfg.table_length : TBL_DEPTH;
        hit = 1'b0;
        slot = 0;
        // scan backward so the lowest matching slot wins
        for (s = int'(lim) - 1; s >= 0; s--) begin
            if (font_codes[s] == it.char_code) begin
                hit = 1'b1;
                slot = s;
            end
        end
        if (!hit) return;
        if (font_cfg.glyphs_per_row == 8'd0) begin
            row  = font_packs[slot][15:14];
            wid  = font_packs[slot][13:9];
            xoff = font_packs[slot][8:0];
        end else begin
            wid  = font_cfg.cell_width;
            row  = slot / font_cfg.glyphs_per_row;
            xoff = (slot % font_cfg.glyphs_per_row) * wid;
        end
        if (wid == 0) return;
        nrows = (font_cfg.cell_height < ROW_LIMIT) ? font_cfg.cell_height : ROW_LIMIT;
        if (nrows == 0) return;
        dst = font_cfg.dest_base + it.y_pos * SCREEN_W + it.x_pos;
        // source strip uses the raw cell height, not the clamped row count
        src = row * font_cfg.cell_height * font_cfg.image_width + xoff;
        for (line = 0; line < nrows; line++) begin
            cp.dest_offset   = dst[15:0];
            cp.source_offset = src[15:0];
            cp.copy_width    = wid[4:0];
            cp.last_row      = (line + 1 == nrows);
            pending_copies.push_back(cp);
            dst = dst + SCREEN_W;
            src = src + font_cfg.image_width;
        end
    endfunction

    always @(posedge i_clk) begin : copy_check
        t_out_item want;
        if (o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (pending_copies.size() == 0) begin
                report_mismatch($sformatf("row copy with none expected: %h", o_out_data));
            end else begin
                want = pending_copies.pop_front();
                check_field("dest_offset", o_out_data.dest_offset, want.dest_offset);
                check_field("source_offset", o_out_data.source_offset, want.source_offset);
                check_field("copy_width", 16'(o_out_data.copy_width), 16'(want.copy_width));
                check_field("last_row", 16'(o_out_data.last_row), 16'(want.last_row));
            end
            copy_cnt++;
        end
        if (stall_left == 0) stall_left = pick_gap(out_stall_pct);
        i_out_stall <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
    end

    // valid stays high across back-to-back items; this task drops it only for a gap
    task automatic send_item(input t_in_item it);
        int gap;
        gap = pick_gap(in_gap_pct);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        expect_row_copies(it);
    endtask

    task automatic load_slot(input int slot, input logic [7:0] code,
                             input logic [15:0] pack);
        logic [63:0] junk;
        t_in_item    it;
        junk = {$urandom, $urandom};
        it = junk[$bits(t_in_item)-1:0];
        it.op          = OP_LOAD;
        it.entry_index = slot[6:0];
        it.entry_code  = code;
        it.entry_pack  = pack;
        send_item(it);
    endtask

    task automatic draw_char(input logic [7:0] code, input logic [8:0] x,
                             input logic [7:0] y);
        logic [63:0] junk;
        t_in_item    it;
        junk = {$urandom, $urandom};
        it = junk[$bits(t_in_item)-1:0];
        it.op        = OP_DRAW;
        it.char_code = code;
        it.x_pos     = x;
        it.y_pos     = y;
        send_item(it);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_copies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_GLYPHS_PER_ROW: font_cfg.glyphs_per_row = val[7:0];
            CFG_CELL_WIDTH:     font_cfg.cell_width     = val[4:0];
            CFG_CELL_HEIGHT:    font_cfg.cell_height    = val[5:0];
            CFG_IMAGE_WIDTH:    font_cfg.image_width    = val[11:0];
            CFG_TABLE_LENGTH:   font_cfg.table_length   = val[7:0];
            CFG_DEST_BASE:      font_cfg.dest_base      = val;
            default: ;
        endcase
    endtask

    task automatic set_cfg(input t_cfg c);
        settle();
        write_reg(CFG_GLYPHS_PER_ROW, 16'(c.glyphs_per_row));
        write_reg(CFG_CELL_WIDTH, 16'(c.cell_width));
        write_reg(CFG_CELL_HEIGHT, 16'(c.cell_height));
        write_reg(CFG_IMAGE_WIDTH, 16'(c.image_width));
        write_reg(CFG_TABLE_LENGTH, 16'(c.table_length));
        write_reg(CFG_DEST_BASE, c.dest_base);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_prop_glyphs();
        t_cfg c;
        int   s;
        in_gap_pct    = 30;
        out_stall_pct = 30;
        draw_char(8'h41, 9'd10, 8'd10);              // no font loaded yet
        load_slot(0, 8'h41, {2'd0, 5'd8, 9'd0});
        load_slot(1, 8'hFF, 16'hFFFF);
        load_slot(2, 8'h42, {2'd3, 5'd0, 9'd100});   // zero width
        load_slot(3, 8'h41, {2'd1, 5'd4, 9'd40});    // shadowed by slot 0
        load_slot(4, 8'h01, {2'd2, 5'd1, 9'd256});
        load_slot(5, 8'h00, {2'd1, 5'd9, 9'd9});
        load_slot(6, 8'h80, 16'h5A5A);
        load_slot(7, 8'h7F, {2'd1, 5'd16, 9'h0AA});
        for (s = 8; s < 12; s++) load_slot(s, 8'h90 + 8'(s), 16'($urandom));
        c = font_cfg;
        c.table_length = 8'd8;
        set_cfg(c);
        draw_char(8'h00, 9'd5, 8'd5);
        draw_char(8'h41, 9'd0, 8'd0);
        draw_char(8'hFF, 9'd319, 8'd199);
        draw_char(8'h42, 9'd1, 8'd1);
        draw_char(8'h80, 9'd100, 8'd50);
        draw_char(8'h7F, 9'd256, 8'd128);
        draw_char(8'h01, 9'd511, 8'd255);
        draw_char(8'h98, 9'd0, 8'd0);                // slot 8 is past the table end
        draw_char(8'h55, 9'd0, 8'd0);
    endtask

    task automatic test_config_extremes();
        t_cfg c;
        c = font_cfg;
        c.cell_height  = 6'd63;                      // row count clamps
        c.image_width  = 12'd4095;
        c.dest_base    = 16'hFFFF;
        c.table_length = 8'd12;
        set_cfg(c);
        draw_char(8'hFF, 9'd319, 8'd199);
        draw_char(8'h9B, 9'd3, 8'd7);
        draw_char(8'h01, 9'd0, 8'd0);
        c.cell_height = 6'd0;
        set_cfg(c);
        draw_char(8'h41, 9'd0, 8'd0);
        c.cell_height = 6'd32;
        c.image_width = 12'd0;
        set_cfg(c);
        draw_char(8'h7F, 9'd20, 8'd20);
        c.cell_height = 6'd1;
        c.image_width = 12'd1;
        c.dest_base   = 16'd0;
        set_cfg(c);
        draw_char(8'h41, 9'd300, 8'd190);
    endtask

    task automatic test_mono_glyphs();
        t_cfg c;
        c = font_cfg;
        c.glyphs_per_row = 8'd1;
        c.cell_width     = 5'd31;
        c.cell_height    = 6'd1;
        c.image_width    = 12'd1;
        c.table_length   = 8'd12;
        set_cfg(c);
        draw_char(8'h7F, 9'd8, 8'd8);
        draw_char(8'h9B, 9'd0, 8'd199);
        draw_char(8'h42, 9'd319, 8'd0);              // width comes from the cell
        c.glyphs_per_row = 8'd255;
        c.cell_width     = 5'd0;
        set_cfg(c);
        draw_char(8'h41, 9'd0, 8'd0);
        c.cell_width  = 5'd5;
        c.cell_height = 6'd32;
        c.image_width = 12'd4095;
        set_cfg(c);
        draw_char(8'h9B, 9'd40, 8'd40);
        c.glyphs_per_row = 8'd3;
        c.cell_width     = 5'd8;
        c.cell_height    = 6'd8;
        c.image_width    = 12'd320;
        set_cfg(c);
        draw_char(8'h80, 9'd64, 8'd16);
        draw_char(8'h01, 9'd72, 8'd16);
    endtask

    task automatic test_full_table();
        t_cfg       c;
        int         s, k;
        bit         used;
        logic [7:0] tail_code, miss_code;
        in_gap_pct    = 10;
        out_stall_pct = 10;
        for (s = 12; s < TBL_DEPTH - 1; s++) load_slot(s, 8'($urandom), 16'($urandom));
        // codes held by no slot: one goes in the last slot, one stays missing
        tail_code = 8'd0;
        miss_code = 8'd0;
        for (k = 255; k > 0; k--) begin
            used = 1'b0;
            for (s = 0; s < TBL_DEPTH - 1; s++)
                if (font_codes[s] == 8'(k)) used = 1'b1;
            if (!used) begin
                if (tail_code == 8'd0) tail_code = 8'(k);
                else if (miss_code == 8'd0) miss_code = 8'(k);
            end
        end
        load_slot(TBL_DEPTH - 1, tail_code, {2'($urandom), 5'd12, 9'($urandom)});
        c = font_cfg;
        c.glyphs_per_row = 8'd0;
        c.cell_height    = 6'd4;
        c.table_length   = 8'd128;
        c.dest_base      = 16'($urandom);
        set_cfg(c);
        draw_char(tail_code, 9'd160, 8'd100);
        draw_char(miss_code, 9'd0, 8'd0);
        c.table_length = 8'd255;                     // search still stops at the table end
        set_cfg(c);
        draw_char(tail_code, 9'd1, 8'd2);
        draw_char(miss_code, 9'd3, 8'd4);
        c.glyphs_per_row = 8'd255;
        c.cell_width     = 5'd7;
        c.table_length   = 8'd128;
        set_cfg(c);
        draw_char(tail_code, 9'd200, 8'd150);
        c.glyphs_per_row = 8'd1;
        set_cfg(c);
        draw_char(tail_code, 9'd5, 8'd5);
    endtask

    task automatic test_random_text();
        t_cfg       c;
        int         round, n, lim;
        logic [7:0] code;
        logic [8:0] x;
        logic [7:0] y;
        for (round = 0; round < 3; round++) begin
            c = font_cfg;
            c.glyphs_per_row = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 255));
            if (round == 1) c.glyphs_per_row = 8'd255;
            c.cell_width = ($urandom_range(0, 9) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
            c.cell_height = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                                        : 6'($urandom_range(1, 8));
            case ($urandom_range(0, 5))
                0:       c.image_width = 12'd0;
                1:       c.image_width = 12'd4095;
                default: c.image_width = 12'($urandom_range(1, 4095));
            endcase
            c.table_length = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                         : 8'($urandom_range(1, 128));
            c.dest_base = 16'($urandom);
            set_cfg(c);
            case ($urandom_range(0, 2))
                0:       in_gap_pct = 0;
                1:       in_gap_pct = 20;
                default: in_gap_pct = 60;
            endcase
            case ($urandom_range(0, 2))
                0:       out_stall_pct = 0;
                1:       out_stall_pct = 20;
                default: out_stall_pct = 60;
            endcase
            lim = (font_cfg.table_length < TBL_DEPTH) ? font_cfg.table_length : TBL_DEPTH;
            for (n = 0; n < 5; n++) begin
                if ($urandom_range(0, 3) == 0) begin
                    load_slot($urandom_range(0, TBL_DEPTH - 1), 8'($urandom), 16'($urandom));
                end else begin
                    // mostly codes the search will find
                    if (lim > 0 && $urandom_range(0, 9) < 7)
                        code = font_codes[$urandom_range(0, lim - 1)];
                    else
                        code = 8'($urandom);
                    x = ($urandom_range(0, 4) == 0) ? 9'($urandom) : 9'($urandom_range(0, 319));
                    y = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 199));
                    draw_char(code, x, y);
                end
            end
        end
    endtask

    initial begin
        font_cfg      = CFG_RESET;
        in_gap_pct    = 0;
        out_stall_pct = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_stall <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_prop_glyphs();
        test_config_extremes();
        test_mono_glyphs();
        test_full_table();
        test_random_text();
        settle();
        if (fail_cnt == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
